>>> rtl/core/hrs_pkg.sv
// Shared types and constants of the HTTP response header scanner.
// No dependencies; every module of the scanner imports this package.
package hrs_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF = 32;
    localparam int unsigned OUT_LEN_W        = 32;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned LEN_200 = 15;
    localparam int unsigned LEN_201 = 20;
    localparam int unsigned LEN_404 = 29;
    localparam int unsigned LEN_CL  = 15;
    localparam int unsigned LEN_TE  = 18;
    localparam int unsigned LEN_CH  = 7;

    localparam logic [8*LEN_200-1:0] PAT_200 = "HTTP/1.1 200 OK";
    localparam logic [8*LEN_201-1:0] PAT_201 = "HTTP/1.1 201 Created";
    localparam logic [8*LEN_404-1:0] PAT_404 = "HTTP/1.1 404 Object Not Found";
    localparam logic [8*LEN_CL-1:0]  PAT_CL  = "Content-Length:";
    localparam logic [8*LEN_TE-1:0]  PAT_TE  = "Transfer-Encoding:";
    localparam logic [8*LEN_CH-1:0]  PAT_CH  = "chunked";

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } t_len_phase;

    // Per-request step control shared by the matchers and the length parser.
    typedef struct packed {
        logic en;        // a request is processed this cycle
        logic restart;   // treat the stored state as reset first
        logic line_end;  // CR closes the current line
        logic byte_en;   // byte enters the line text
    } t_step;

endpackage

>>> rtl/core/hrs_match.sv
// Streaming shift-and substring matcher for one constant pattern.
// Depends on hrs_pkg for the step control struct.
module hrs_match #(
    parameter int unsigned          PAT_LEN  = 2,
    parameter logic [8*PAT_LEN-1:0] PAT_TEXT = "ab"
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hrs_pkg::t_step i_step,
    input  logic [7:0]    i_byte,
    output logic          o_hit
);
    import hrs_pkg::*;

    logic [PAT_LEN-1:0] r_prog;
    logic [PAT_LEN-1:0] n_prog;
    logic [PAT_LEN-1:0] w_cur;
    logic [PAT_LEN-1:0] w_mask;
    logic [PAT_LEN-1:0] w_shift;

    // Bit k of the mask: pattern character k equals the byte.
    always_comb begin
        for (int k = 0; k < PAT_LEN; k++) begin
            w_mask[k] = (PAT_TEXT[8*(PAT_LEN-1-k) +: 8] == i_byte);
        end
    end

    assign w_cur   = i_step.restart ? '0 : r_prog;
    assign w_shift = {w_cur[PAT_LEN-2:0], 1'b1} & w_mask;
    assign o_hit   = i_step.byte_en & w_shift[PAT_LEN-1];

    always_comb begin
        if (i_step.line_end) begin
            n_prog = '0;
        end else if (i_step.byte_en) begin
            n_prog = w_shift;
        end else begin
            n_prog = w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= '0;
        end else if (i_step.en) begin
            r_prog <= n_prog;
        end
    end

endmodule

>>> rtl/core/hrs_len.sv
// Content-Length value parser: skip blanks, then accumulate decimal digits
// with saturation. Depends on hrs_pkg for constants, phase enum and step struct.
module hrs_len #(
    parameter int unsigned LENGTH_WIDTH = hrs_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hrs_pkg::t_step          i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_cl_start,
    output logic [LENGTH_WIDTH-1:0] o_acc,
    output logic                    o_ovf
);
    import hrs_pkg::*;

    t_len_phase              r_phase, n_phase;
    logic [LENGTH_WIDTH-1:0] r_acc, n_acc;
    logic                    r_ovf, n_ovf;

    t_len_phase              w_cur_phase, w_phase_a;
    logic [LENGTH_WIDTH-1:0] w_cur_acc, w_acc_b;
    logic                    w_cur_ovf, w_ovf_b;
    logic                    w_digit;
    logic                    w_blank;
    logic                    w_sign;
    logic [LENGTH_WIDTH+3:0] w_ext;
    logic [LENGTH_WIDTH+3:0] w_prod;

    assign w_cur_phase = i_step.restart ? PH_SEARCH : r_phase;
    assign w_cur_acc   = i_step.restart ? '0 : r_acc;
    assign w_cur_ovf   = i_step.restart ? 1'b0 : r_ovf;

    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign w_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);

    // acc * 10 + digit, four guard bits catch overflow
    assign w_ext  = {4'b0000, w_cur_acc};
    assign w_prod = (w_ext << 3) + (w_ext << 1) + (LENGTH_WIDTH+4)'(i_byte[3:0]);

    always_comb begin
        w_phase_a = w_cur_phase;
        unique case (w_cur_phase)
            PH_SKIP: begin
                if (w_blank) begin
                    w_phase_a = PH_SKIP;
                end else if (w_digit) begin
                    w_phase_a = PH_DIGITS;
                end else begin
                    w_phase_a = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (!w_digit) begin
                    w_phase_a = PH_DONE;
                end
            end
            PH_SEARCH, PH_DONE: begin
                w_phase_a = w_cur_phase;
            end
        endcase
    end

    always_comb begin
        w_acc_b = w_cur_acc;
        w_ovf_b = w_cur_ovf;
        // a sign in place of the first digit forces zero
        if (w_cur_phase == PH_SKIP && w_sign) begin
            w_acc_b = '0;
        end
        if (w_phase_a == PH_DIGITS) begin
            if (|w_prod[LENGTH_WIDTH+3:LENGTH_WIDTH]) begin
                w_acc_b = '1;
                w_ovf_b = 1'b1;
            end else begin
                w_acc_b = w_prod[LENGTH_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        if (i_step.line_end) begin
            n_phase = PH_SEARCH;
            n_acc   = '0;
            n_ovf   = 1'b0;
        end else if (i_step.byte_en && i_cl_start) begin
            n_phase = PH_SKIP;
            n_acc   = '0;
            n_ovf   = 1'b0;
        end else if (i_step.byte_en) begin
            n_phase = w_phase_a;
            n_acc   = w_acc_b;
            n_ovf   = w_ovf_b;
        end else begin
            n_phase = w_cur_phase;
            n_acc   = w_cur_acc;
            n_ovf   = w_cur_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step.en) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
        end
    end

    assign o_acc = r_acc;
    assign o_ovf = r_ovf;

endmodule

>>> rtl/core/http_response_header_scanner.sv
// Top level of the HTTP response header scanner: input register, CR/LF framing,
// line and sticky flags. Depends on hrs_pkg, hrs_match and hrs_len.
//
//  Channel  Handshake           Payload
//  -------  ------------------  ------------------------------------------------
//  in       i_valid / o_ready   i_data_byte[7:0], i_restart
//  out      o_valid / i_ready   o_header_done, o_status_ok, o_status_not_found,
//                               o_is_chunked, o_has_length,
//                               o_content_length[31:0], o_length_saturated
//
// One byte per cycle sustained while the result channel is not stalled. A request
// accepted into the input register is run through the framing, matcher and digit
// logic into the state registers, which also serve as the result register, once
// the result slot is free or being drained; its result is then offered on the
// output channel.
// Reset (i_rst_n low at a clock edge) empties both stages and clears all flags.
// A stalled result holds the state; the input register still takes one more
// request while the result waits, so o_ready falls only when both stages are full.
module http_response_header_scanner #(
    parameter int unsigned LENGTH_WIDTH = hrs_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_header_done,
    output logic                          o_status_ok,
    output logic                          o_status_not_found,
    output logic                          o_is_chunked,
    output logic                          o_has_length,
    output logic [hrs_pkg::OUT_LEN_W-1:0] o_content_length,
    output logic                          o_length_saturated
);
    import hrs_pkg::*;

    // ---------------------------------------------------------------- input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;
    logic       r_out_valid;
    logic       w_proc;

    // Process the held request when the result slot is free or being drained.
    assign w_proc  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_proc;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    // ---------------------------------------------------------------- framing
    logic r_cr_pend, n_cr_pend;
    logic r_first, n_first;
    logic r_hdr_done, n_hdr_done;
    logic w_cr_cur, w_first_cur, w_hdr_cur;
    logic w_is_lf, w_is_cr;
    t_step w_step;

    assign w_cr_cur    = r_in_restart ? 1'b0 : r_cr_pend;
    assign w_first_cur = r_in_restart ? 1'b0 : r_first;
    assign w_hdr_cur   = r_in_restart ? 1'b0 : r_hdr_done;
    assign w_is_lf     = (r_in_byte == CH_LF);
    assign w_is_cr     = (r_in_byte == CH_CR);

    // Order matters: CR LF CR LF ends the header, CR LF and the CR after it
    // stay out of the line text, anything else is either a line end or text.
    always_comb begin
        n_cr_pend        = w_cr_cur;
        n_first          = w_first_cur;
        n_hdr_done       = w_hdr_cur;
        w_step.en        = w_proc;
        w_step.restart   = r_in_restart;
        w_step.line_end  = 1'b0;
        w_step.byte_en   = 1'b0;
        priority if (w_hdr_cur) begin
            // ignore bytes after the header
        end else if (w_is_lf && w_cr_cur && w_first_cur) begin
            n_hdr_done = 1'b1;
        end else if (w_is_lf && w_cr_cur) begin
            n_cr_pend = 1'b0;
            n_first   = 1'b1;
        end else if (w_is_cr && w_first_cur) begin
            n_cr_pend = 1'b1;
        end else begin
            n_first         = 1'b0;
            n_cr_pend       = w_is_cr;
            w_step.line_end = w_is_cr;
            w_step.byte_en  = !w_is_cr;
        end
    end

    // ---------------------------------------------------------------- matchers
    logic w_hit_200, w_hit_201, w_hit_404, w_hit_cl, w_hit_te, w_hit_ch;

    hrs_match #(.PAT_LEN(LEN_200), .PAT_TEXT(PAT_200)) u_m200 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_200)
    );
    hrs_match #(.PAT_LEN(LEN_201), .PAT_TEXT(PAT_201)) u_m201 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_201)
    );
    hrs_match #(.PAT_LEN(LEN_404), .PAT_TEXT(PAT_404)) u_m404 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_404)
    );
    hrs_match #(.PAT_LEN(LEN_CL), .PAT_TEXT(PAT_CL)) u_mcl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_cl)
    );
    hrs_match #(.PAT_LEN(LEN_TE), .PAT_TEXT(PAT_TE)) u_mte (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_te)
    );
    hrs_match #(.PAT_LEN(LEN_CH), .PAT_TEXT(PAT_CH)) u_mch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_byte(r_in_byte),
        .o_hit(w_hit_ch)
    );

    // ---------------------------------------------------------------- line flags
    logic r_lf_ok, r_lf_nf, r_lf_cl, r_lf_te, r_lf_ch;
    logic n_lf_ok, n_lf_nf, n_lf_cl, n_lf_te, n_lf_ch;
    logic w_lf_ok, w_lf_nf, w_lf_cl, w_lf_te, w_lf_ch;
    logic w_cl_start;

    assign w_lf_ok = r_in_restart ? 1'b0 : r_lf_ok;
    assign w_lf_nf = r_in_restart ? 1'b0 : r_lf_nf;
    assign w_lf_cl = r_in_restart ? 1'b0 : r_lf_cl;
    assign w_lf_te = r_in_restart ? 1'b0 : r_lf_te;
    assign w_lf_ch = r_in_restart ? 1'b0 : r_lf_ch;

    // Only the first Content-Length: of a line restarts the value parse.
    assign w_cl_start = w_hit_cl && !w_lf_cl;

    always_comb begin
        if (w_step.line_end) begin
            n_lf_ok = 1'b0;
            n_lf_nf = 1'b0;
            n_lf_cl = 1'b0;
            n_lf_te = 1'b0;
            n_lf_ch = 1'b0;
        end else if (w_step.byte_en) begin
            n_lf_ok = w_lf_ok | w_hit_200 | w_hit_201;
            n_lf_nf = w_lf_nf | w_hit_404;
            n_lf_cl = w_lf_cl | w_hit_cl;
            n_lf_te = w_lf_te | w_hit_te;
            // chunked counts only after Transfer-Encoding: on an earlier byte
            n_lf_ch = w_lf_ch | (w_hit_ch & w_lf_te);
        end else begin
            n_lf_ok = w_lf_ok;
            n_lf_nf = w_lf_nf;
            n_lf_cl = w_lf_cl;
            n_lf_te = w_lf_te;
            n_lf_ch = w_lf_ch;
        end
    end

    // ---------------------------------------------------------------- length parse
    logic [LENGTH_WIDTH-1:0] w_acc;
    logic                    w_ovf;

    hrs_len #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_len (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_cl_start (w_cl_start),
        .o_acc      (w_acc),
        .o_ovf      (w_ovf)
    );

    // ---------------------------------------------------------------- sticky flags
    logic r_ok, r_nf, r_chunked, r_haslen, r_sat;
    logic n_ok, n_nf, n_chunked, n_haslen, n_sat;
    logic [LENGTH_WIDTH-1:0] r_len_value, n_len_value;
    logic w_ok, w_nf, w_chunked, w_haslen, w_sat;
    logic [LENGTH_WIDTH-1:0] w_len_value;

    assign w_ok        = r_in_restart ? 1'b0 : r_ok;
    assign w_nf        = r_in_restart ? 1'b0 : r_nf;
    assign w_chunked   = r_in_restart ? 1'b0 : r_chunked;
    assign w_haslen    = r_in_restart ? 1'b0 : r_haslen;
    assign w_sat       = r_in_restart ? 1'b0 : r_sat;
    assign w_len_value = r_in_restart ? '0 : r_len_value;

    // At a line end, take the length or chunked mark only while neither is known.
    always_comb begin
        n_ok        = w_ok;
        n_nf        = w_nf;
        n_chunked   = w_chunked;
        n_haslen    = w_haslen;
        n_sat       = w_sat;
        n_len_value = w_len_value;
        if (w_step.line_end) begin
            n_ok = w_ok | w_lf_ok;
            n_nf = w_nf | w_lf_nf;
            if (!(w_haslen || w_chunked)) begin
                if (w_lf_cl) begin
                    n_haslen    = 1'b1;
                    n_len_value = w_acc;
                    n_sat       = w_sat | w_ovf;
                end else if (w_lf_ch) begin
                    n_chunked = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pend   <= 1'b0;
            r_first     <= 1'b0;
            r_hdr_done  <= 1'b0;
            r_lf_ok     <= 1'b0;
            r_lf_nf     <= 1'b0;
            r_lf_cl     <= 1'b0;
            r_lf_te     <= 1'b0;
            r_lf_ch     <= 1'b0;
            r_ok        <= 1'b0;
            r_nf        <= 1'b0;
            r_chunked   <= 1'b0;
            r_haslen    <= 1'b0;
            r_sat       <= 1'b0;
            r_len_value <= '0;
        end else if (w_proc) begin
            r_cr_pend   <= n_cr_pend;
            r_first     <= n_first;
            r_hdr_done  <= n_hdr_done;
            r_lf_ok     <= n_lf_ok;
            r_lf_nf     <= n_lf_nf;
            r_lf_cl     <= n_lf_cl;
            r_lf_te     <= n_lf_te;
            r_lf_ch     <= n_lf_ch;
            r_ok        <= n_ok;
            r_nf        <= n_nf;
            r_chunked   <= n_chunked;
            r_haslen    <= n_haslen;
            r_sat       <= n_sat;
            r_len_value <= n_len_value;
        end
    end

    // ---------------------------------------------------------------- results
    // The state registers change only on a processed request, so they hold
    // steady while a result is stalled.
    assign o_header_done      = r_hdr_done;
    assign o_status_ok        = r_ok;
    assign o_status_not_found = r_nf;
    assign o_is_chunked       = r_chunked;
    assign o_has_length       = r_haslen;
    assign o_content_length   = OUT_LEN_W'(r_len_value);
    assign o_length_saturated = r_sat;

    // ---------------------------------------------------------------- assertions
    a_hdr_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hdr_done) |-> ($past(r_in_byte) == CH_LF))
        else $error("header end flagged on a byte other than LF");

    a_sat_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> r_haslen)
        else $error("saturation flag without a length");

    a_len_xor_chunked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_haslen && r_chunked))
        else $error("length and chunked both taken");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_haslen |-> (r_len_value == '0))
        else $error("length value set without a length header");

endmodule

>>> bench/http_response_header_scanner_tb.sv
// Self-checking bench for the HTTP response header scanner: streams whole responses,
// broken sequences and noise bytes, predicts each result and compares every field.
// Depends on hrs_pkg and http_response_header_scanner.
module http_response_header_scanner_tb;
    import hrs_pkg::*;

    typedef logic [7:0] t_byte;

    // One request as it goes onto the input channel.
    typedef struct {
        t_byte data;
        logic  restart;
    } t_byte_req;

    // One result as it leaves the output channel.
    typedef struct {
        logic                 hdr_done;
        logic                 ok;
        logic                 not_found;
        logic                 chunked;
        logic                 has_len;
        logic [OUT_LEN_W-1:0] clen;
        logic                 sat;
    } t_scan_flags;

    localparam int NUM_PAT = 6;
    localparam int M_200   = 0;
    localparam int M_201   = 1;
    localparam int M_404   = 2;
    localparam int M_CL    = 3;
    localparam int M_TE    = 4;
    localparam int M_CH    = 5;

    localparam longint unsigned LEN_MAX   = (64'd1 << LENGTH_WIDTH_DEF) - 64'd1;
    localparam int              RAND_REQS = 850;

    string pat_txt [NUM_PAT] = '{
        "HTTP/1.1 200 OK",
        "HTTP/1.1 201 Created",
        "HTTP/1.1 404 Object Not Found",
        "Content-Length:",
        "Transfer-Encoding:",
        "chunked"
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_data_byte = '0;
    logic                 i_restart   = 1'b0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_header_done;
    logic                 o_status_ok;
    logic                 o_status_not_found;
    logic                 o_is_chunked;
    logic                 o_has_length;
    logic [OUT_LEN_W-1:0] o_content_length;
    logic                 o_length_saturated;

    http_response_header_scanner u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_header_done      (o_header_done),
        .o_status_ok        (o_status_ok),
        .o_status_not_found (o_status_not_found),
        .o_is_chunked       (o_is_chunked),
        .o_has_length       (o_has_length),
        .o_content_length   (o_content_length),
        .o_length_saturated (o_length_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests still to send, and results predicted but not yet seen.
    t_byte_req   byte_requests [$];
    t_scan_flags scan_results_due [$];

    int   fail_cnt    = 0;
    int   taken_cnt   = 0;
    int   total_reqs  = 1;
    logic req_taken   = 1'b0;
    logic restart_next = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: framing, sticky flags, per-line flags, matcher
    // progress and the Content-Length digit parser.
    // ------------------------------------------------------------------
    logic            cr_seen;
    logic            crlf_seen;
    logic            hdr_end;
    logic            st_ok;
    logic            st_nf;
    logic            st_chunked;
    logic            st_has_len;
    logic            st_sat;
    logic            ln_ok;
    logic            ln_nf;
    logic            ln_cl;
    logic            ln_te;
    logic            ln_ch;
    int unsigned     pat_prog [NUM_PAT];
    t_len_phase      len_phase;
    longint unsigned len_acc;
    longint unsigned len_val;
    logic            len_ovf;

    // Longest prefix of p that ends the text matched so far (j chars) plus c.
    function automatic int unsigned next_prefix(string p, int unsigned j, t_byte c);
        int unsigned n;
        int unsigned k;
        logic        same;
        n = p.len();
        k = (j + 1 < n) ? j + 1 : n;
        if (j > n) j = n;
        for (; k > 0; k--) begin
            if (t_byte'(p[k-1]) == c && k - 1 <= j) begin
                same = 1'b1;
                for (int unsigned m = 0; m + 1 < k; m++) begin
                    if (p[m] != p[j - (k - 1) + m]) same = 1'b0;
                end
                if (same) return k;
            end
        end
        return 0;
    endfunction

    function automatic void clear_line();
        ln_ok   = 1'b0;
        ln_nf   = 1'b0;
        ln_cl   = 1'b0;
        ln_te   = 1'b0;
        ln_ch   = 1'b0;
        foreach (pat_prog[i]) pat_prog[i] = 0;
        len_phase = PH_SEARCH;
        len_acc   = 0;
        len_ovf   = 1'b0;
    endfunction

    function automatic void clear_scan();
        cr_seen    = 1'b0;
        crlf_seen  = 1'b0;
        hdr_end    = 1'b0;
        st_ok      = 1'b0;
        st_nf      = 1'b0;
        st_chunked = 1'b0;
        st_has_len = 1'b0;
        st_sat     = 1'b0;
        len_val    = 0;
        clear_line();
    endfunction

    // Advance the predictor by one accepted request and queue its result.
    function automatic void scan_byte(t_byte c, logic rst);
        logic            is_digit;
        logic            hit [NUM_PAT];
        longint unsigned digit;
        t_scan_flags     res;
        if (rst) clear_scan();
        if (!hdr_end) begin
            if (c == CH_LF && cr_seen && crlf_seen) begin
                hdr_end = 1'b1;
            end else if (c == CH_LF && cr_seen) begin
                cr_seen   = 1'b0;
                crlf_seen = 1'b1;
            end else if (c == CH_CR && crlf_seen) begin
                // CR of CR LF CR: stays out of the line, may start the end of header
                cr_seen = 1'b1;
            end else if (c == CH_CR) begin
                // Close the line: fold its flags into the sticky ones
                crlf_seen = 1'b0;
                cr_seen   = 1'b1;
                if (ln_ok) st_ok = 1'b1;
                if (ln_nf) st_nf = 1'b1;
                if (!st_has_len && !st_chunked) begin
                    if (ln_cl) begin
                        st_has_len = 1'b1;
                        len_val    = len_acc;
                        if (len_ovf) st_sat = 1'b1;
                    end else if (ln_ch) begin
                        st_chunked = 1'b1;
                    end
                end
                clear_line();
            end else begin
                crlf_seen = 1'b0;
                cr_seen   = 1'b0;
                is_digit  = (c >= CH_ZERO && c <= CH_NINE);
                if (len_phase == PH_SKIP) begin
                    if (c != CH_SPACE && c != CH_TAB) begin
                        if (is_digit) begin
                            len_phase = PH_DIGITS;
                        end else begin
                            // a sign in place of the first digit yields zero
                            if (c == CH_PLUS || c == CH_MINUS) len_acc = 0;
                            len_phase = PH_DONE;
                        end
                    end
                end else if (len_phase == PH_DIGITS && !is_digit) begin
                    len_phase = PH_DONE;
                end
                if (len_phase == PH_DIGITS) begin
                    digit = c - CH_ZERO;
                    if (len_acc > (LEN_MAX - digit) / 10) begin
                        len_acc = LEN_MAX;
                        len_ovf = 1'b1;
                    end else begin
                        len_acc = len_acc * 10 + digit;
                    end
                end
                for (int i = 0; i < NUM_PAT; i++) begin
                    pat_prog[i] = next_prefix(pat_txt[i], pat_prog[i], c);
                    hit[i]      = (pat_prog[i] == pat_txt[i].len());
                end
                if (hit[M_200] || hit[M_201]) ln_ok = 1'b1;
                if (hit[M_404]) ln_nf = 1'b1;
                // chunked only counts once Transfer-Encoding: came earlier
                if (hit[M_CH] && ln_te) ln_ch = 1'b1;
                if (hit[M_TE]) ln_te = 1'b1;
                if (hit[M_CL] && !ln_cl) begin
                    ln_cl     = 1'b1;
                    len_phase = PH_SKIP;
                    len_acc   = 0;
                    len_ovf   = 1'b0;
                end
            end
        end
        res.hdr_done  = hdr_end;
        res.ok        = st_ok;
        res.not_found = st_nf;
        res.chunked   = st_chunked;
        res.has_len   = st_has_len;
        res.clen      = len_val[OUT_LEN_W-1:0];
        res.sat       = st_sat;
        scan_results_due.push_back(res);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders: append requests to the pending queue.
    // ------------------------------------------------------------------
    function automatic void push_byte(t_byte c);
        t_byte_req r;
        r.data       = c;
        r.restart    = restart_next;
        restart_next = 1'b0;
        byte_requests.push_back(r);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void push_digits(int n);
        repeat (n) push_byte(CH_ZERO + t_byte'($urandom_range(9)));
    endfunction

    // Blanks, then a number in one of several shapes, then maybe trailing text.
    function automatic void push_length_text();
        repeat ($urandom_range(2)) begin
            if ($urandom_range(1)) push_byte(CH_SPACE);
            else push_byte(CH_TAB);
        end
        // shape 0 leaves the value empty
        case ($urandom_range(7))
            1: begin
                if ($urandom_range(1)) push_byte(CH_PLUS);
                else push_byte(CH_MINUS);
                push_digits($urandom_range(3));
            end
            2: push_text("4294967295");
            3: push_text("4294967296");
            4: push_digits($urandom_range(11, 14));
            5, 6, 7: push_digits($urandom_range(1, 6));
            default: ;
        endcase
        case ($urandom_range(5))
            0: push_text(" ;q=1");
            1: push_byte(t_byte'($urandom_range(255)));
            default: ;
        endcase
    endfunction

    function automatic void push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endfunction

    // A response with a random status line, random header lines and a random body.
    function automatic void queue_response();
        restart_next = 1'b1;
        case ($urandom_range(7))
            0: push_text("HTTP/1.1 200 OK");
            1: push_text("HTTP/1.1 201 Created");
            2: push_text("HTTP/1.1 404 Object Not Found");
            3: push_text("HTTP/1.1 HTTP/1.1 200 OK");
            4: push_text("HTTP/1.1 500 Internal Error");
            5: push_text("HTTP/1.1 20");
            6: push_text("HTTP/1.1 404 Not Found");
            default: ;
        endcase
        push_crlf();
        repeat ($urandom_range(1, 5)) begin
            // occasionally restart in the middle of a header
            if ($urandom_range(39) == 0) restart_next = 1'b1;
            case ($urandom_range(8))
                0, 1: begin
                    push_text("Content-Length:");
                    push_length_text();
                end
                2: begin
                    push_text("Transfer-Encoding:");
                    if ($urandom_range(1)) push_text(" chunked");
                    else push_text(" gzip, chunked");
                end
                3: push_text("Transfer-Encoding: gzip");
                4: push_text("chunked Transfer-Encoding: x");
                5: begin
                    push_text("Transfer-Encoding: chunked Content-Length:");
                    push_length_text();
                end
                6: begin
                    push_text("Content-Content-Length:");
                    push_length_text();
                    push_text(" Content-Length: 9");
                end
                7: push_text("HTTP/1.1 201 Created");
                default: repeat ($urandom_range(8)) push_byte(t_byte'($urandom_range(255)));
            endcase
            push_crlf();
        end
        push_crlf();
        repeat ($urandom_range(6)) push_byte(t_byte'($urandom_range(255)));
    endfunction

    // Raw noise and broken framing, rich in CR and LF.
    function automatic void queue_noise();
        repeat ($urandom_range(4, 20)) begin
            if ($urandom_range(7) == 0) restart_next = 1'b1;
            case ($urandom_range(3))
                0: push_byte(CH_CR);
                1: push_byte(CH_LF);
                default: push_byte(t_byte'($urandom_range(255)));
            endcase
        end
    endfunction

    // Idle share in percent for the current third of the run.
    function automatic int idle_pct(logic for_sender);
        int phase;
        phase = (taken_cnt * 3) / total_reqs;
        if (phase == 0) return for_sender ? 32 : 79;
        if (phase == 1) return for_sender ? 79 : 32;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present requests at the falling edge; hold the payload until
    // the previous rising edge accepted it, then advance or idle.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_byte_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (byte_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                nxt = byte_requests.pop_front();
                i_valid     <= 1'b1;
                i_data_byte <= nxt.data;
                i_restart   <= nxt.restart;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Throttle the result channel at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge check each result against the oldest
    // prediction, then predict the request accepted at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_scan_flags want;
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (scan_results_due.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = scan_results_due.pop_front();
                    check_field("header_done", want.hdr_done, o_header_done);
                    check_field("status_ok", want.ok, o_status_ok);
                    check_field("status_not_found", want.not_found, o_status_not_found);
                    check_field("is_chunked", want.chunked, o_is_chunked);
                    check_field("has_length", want.has_len, o_has_length);
                    check_field("content_length", want.clen, o_content_length);
                    check_field("length_saturated", want.sat, o_length_saturated);
                end
            end
            if (i_valid && o_ready) begin
                scan_byte(i_data_byte, i_restart);
                taken_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build all stimulus, reset, drain, report.
    // ------------------------------------------------------------------
    initial begin
        int base;
        clear_scan();

        // Directed: extreme bytes, lone LF, NUL, end of header, ignored tail,
        // CR CR, and a CR LF CR sequence broken by ordinary text.
        restart_next = 1'b1;
        push_byte("H");
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(CH_LF);
        push_byte("x");
        push_crlf();
        push_crlf();
        push_byte("Z");
        restart_next = 1'b1;
        push_byte(CH_CR);
        push_crlf();
        push_byte(CH_CR);
        push_byte("a");
        push_byte(CH_LF);
        push_crlf();
        push_crlf();
        push_byte(8'h80);

        base = byte_requests.size();
        while (byte_requests.size() - base < RAND_REQS) begin
            if ($urandom_range(4) == 0) queue_noise();
            else queue_response();
        end
        total_reqs = byte_requests.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests sent and all results seen, then wait quietly before the report.
        while (byte_requests.size() != 0 || i_valid) @(negedge i_clk);
        while (scan_results_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_cnt == 0) begin
            $display("PASS http_response_header_scanner");
        end else begin
            $display("FAIL http_response_header_scanner");
        end
        $finish;
    end

    // Watchdog: abort a run that stops making progress.
    initial begin
        #2000000;
        $display("FAIL http_response_header_scanner");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hrs_pkg.sv
rtl/core/hrs_match.sv
rtl/core/hrs_len.sv
rtl/core/http_response_header_scanner.sv
bench/http_response_header_scanner_tb.sv
